@@ hdl/sfc_pkg.sv @@
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared constants and types for the sphere/frustum cull pipeline.
// ----------------------------------------------------------------------------
package sfc_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int COEFF_WIDTH_DEF = 16;

    localparam int CFG_INDEX_WIDTH = 4;
    localparam int CFG_DATA_WIDTH  = 64;

    localparam int BASIS_WIDTH     = 48;
    localparam int OFFSET_XY_WIDTH = 64;
    localparam int OFFSET_Z_WIDTH  = 32;
    localparam int PLANES_WIDTH    = 64;
    localparam int CLIP_WIDTH      = 64;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_VIEW_BASIS_X    = 4'd0,
        REG_VIEW_BASIS_Y    = 4'd1,
        REG_VIEW_BASIS_Z    = 4'd2,
        REG_VIEW_OFFSET_XY  = 4'd3,
        REG_VIEW_OFFSET_Z   = 4'd4,
        REG_SIDE_PLANES     = 4'd5,
        REG_VERTICAL_PLANES = 4'd6,
        REG_NEAR_FAR_CLIP   = 4'd7
    } cfg_reg_t;

    // Load enables of the plane-test stages
    typedef struct packed {
        logic prod;
        logic sum;
    } pipe_en_t;

endpackage

@@ hdl/sfc_if.sv @@
// ----------------------------------------------------------------------------
// sfc_if
// Valid/ready channels of the cull block: sphere in, result out, config.
// ----------------------------------------------------------------------------
interface sfc_sphere_if import sfc_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic signed [COORD_WIDTH-1:0] center_z;
    logic        [COORD_WIDTH-2:0] radius;

    modport source (output valid, center_x, center_y, center_z, radius, input ready);
    modport sink   (input valid, center_x, center_y, center_z, radius, output ready);
endinterface

interface sfc_result_if ();
    logic valid;
    logic ready;
    logic visible;

    modport source (output valid, visible, input ready);
    modport sink   (input valid, visible, output ready);
endinterface

interface sfc_cfg_if import sfc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [CFG_DATA_WIDTH-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/sfc_plane_test.sv @@
// ----------------------------------------------------------------------------
// sfc_plane_test
// One side-plane test: p*k0 + vz*k1 > r2, over a product and a sum stage.
// ----------------------------------------------------------------------------
module sfc_plane_test import sfc_pkg::*; #(
    parameter int VW  = 50,
    parameter int KW  = 16,
    parameter int R2W = 59
) (
    input  logic                 clk,
    input  pipe_en_t             en,
    input  logic signed [VW-1:0] p,
    input  logic signed [VW-1:0] vz,
    input  logic signed [KW-1:0] k0,
    input  logic signed [KW-1:0] k1,
    input  logic        [R2W-1:0] r2,
    output logic                 outside
);

    // split view coordinates so each multiplier stays narrow
    localparam int L   = VW / 2;
    localparam int H   = VW - L;
    localparam int LPW = L + 1 + KW;
    localparam int HPW = H + KW;
    localparam int DW  = VW + KW + 1;

    logic signed [LPW-1:0] p_lo_reg, z_lo_reg;
    logic signed [HPW-1:0] p_hi_reg, z_hi_reg;
    logic signed [DW-1:0]  d_reg, d_next;

    always_ff @(posedge clk)
    begin
        if (en.prod)
        begin
            p_lo_reg <= LPW'($signed({1'b0, p[L-1:0]})) * LPW'(k0);
            p_hi_reg <= HPW'($signed(p[VW-1:L])) * HPW'(k0);
            z_lo_reg <= LPW'($signed({1'b0, vz[L-1:0]})) * LPW'(k1);
            z_hi_reg <= HPW'($signed(vz[VW-1:L])) * HPW'(k1);
        end
        if (en.sum)
        begin
            d_reg <= d_next;
        end
    end

    always_comb
    begin
        d_next = (DW'(p_hi_reg) <<< L) + DW'(p_lo_reg)
               + (DW'(z_hi_reg) <<< L) + DW'(z_lo_reg);
    end

    assign outside = d_reg > DW'($signed({1'b0, r2}));

endmodule

@@ hdl/sphere_frustum_cull_top.sv @@
// ----------------------------------------------------------------------------
// sphere_frustum_cull_top
// Bounding sphere against view frustum visibility test, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   sphere : sink channel, one bounding sphere (centre, radius) per transaction.
//   result : source channel, one visible flag per sphere, in arrival order.
//   cfg    : register write channel (view matrix, planes, clips). Always ready;
//            writes to unknown indexes are dropped. Write only while idle.
// Pipeline: a sphere accepted on the sphere channel passes five register stages
//   (product, transform, plane product, plane sum, output stage) to its result.
// Throughput: one sphere per cycle while result.ready holds; the transform
//   and split plane multipliers are each one register stage, so nothing iterates.
// Stalls: every stage holds its own valid bit and loads when it is empty
//   or the stage after it is moving, so a stalled receiver freezes the output
//   register while empty stages upstream keep taking spheres; sphere.ready
//   drops only once all five stages are full.
// Reset: pipeline valid bits and all config registers clear; with zeroed
//   config every sphere reports visible.
// ----------------------------------------------------------------------------
module sphere_frustum_cull_top import sfc_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int COEFF_WIDTH = COEFF_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    sfc_sphere_if.sink   sphere,
    sfc_result_if.source result,
    sfc_cfg_if.sink      cfg
);

    localparam int CW  = COORD_WIDTH;
    localparam int KW  = COEFF_WIDTH;
    localparam int KF  = KW - 2;          // coefficient fraction bits
    localparam int PW  = CW + KW;         // coeff * coord product
    localparam int VW  = CW + KW + 2;     // view-space coordinate, scale CF+KF
    localparam int NW  = VW + 1;          // near/far compare
    localparam int R2W = CW - 1 + 2 * KF; // radius at plane scale

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [BASIS_WIDTH-1:0]     basis_x_reg, basis_y_reg, basis_z_reg;
    logic [OFFSET_XY_WIDTH-1:0] offset_xy_reg;
    logic [OFFSET_Z_WIDTH-1:0]  offset_z_reg;
    logic [PLANES_WIDTH-1:0]    side_reg, vert_reg;
    logic [CLIP_WIDTH-1:0]      clip_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            basis_x_reg   <= '0;
            basis_y_reg   <= '0;
            basis_z_reg   <= '0;
            offset_xy_reg <= '0;
            offset_z_reg  <= '0;
            side_reg      <= '0;
            vert_reg      <= '0;
            clip_reg      <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_VIEW_BASIS_X:    basis_x_reg   <= cfg.data[BASIS_WIDTH-1:0];
                REG_VIEW_BASIS_Y:    basis_y_reg   <= cfg.data[BASIS_WIDTH-1:0];
                REG_VIEW_BASIS_Z:    basis_z_reg   <= cfg.data[BASIS_WIDTH-1:0];
                REG_VIEW_OFFSET_XY:  offset_xy_reg <= cfg.data[OFFSET_XY_WIDTH-1:0];
                REG_VIEW_OFFSET_Z:   offset_z_reg  <= cfg.data[OFFSET_Z_WIDTH-1:0];
                REG_SIDE_PLANES:     side_reg      <= cfg.data[PLANES_WIDTH-1:0];
                REG_VERTICAL_PLANES: vert_reg      <= cfg.data[PLANES_WIDTH-1:0];
                REG_NEAR_FAR_CLIP:   clip_reg      <= cfg.data[CLIP_WIDTH-1:0];
                default: ;  // unknown index: write dropped
            endcase
        end
    end

    // Lane pick; lanes reaching past bit 63 read zero-filled.
    function automatic logic signed [KW-1:0] lane_k(input logic [63:0] word, input int idx);
        logic [127:0] pad;
        pad = {64'd0, word};
        return pad[idx*KW +: KW];
    endfunction

    function automatic logic signed [CW-1:0] lane_c(input logic [63:0] word, input int idx);
        logic [127:0] pad;
        pad = {64'd0, word};
        return pad[idx*CW +: CW];
    endfunction

    logic signed [KW-1:0] m [3][3];   // m[row = input axis][col = view axis]
    logic signed [CW-1:0] off [3];
    logic signed [CW-1:0] near_c, far_c;
    logic signed [KW-1:0] left_a, left_c, right_a, right_c;
    logic signed [KW-1:0] top_b, top_c, bot_b, bot_c;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            m[i][0] = lane_k({16'd0, basis_x_reg}, i);
            m[i][1] = lane_k({16'd0, basis_y_reg}, i);
            m[i][2] = lane_k({16'd0, basis_z_reg}, i);
        end
        off[0]  = lane_c(offset_xy_reg, 0);
        off[1]  = lane_c(offset_xy_reg, 1);
        off[2]  = lane_c({32'd0, offset_z_reg}, 0);
        near_c  = lane_c(clip_reg, 0);
        far_c   = lane_c(clip_reg, 1);
        left_a  = lane_k(side_reg, 0);
        left_c  = lane_k(side_reg, 1);
        right_a = lane_k(side_reg, 2);
        right_c = lane_k(side_reg, 3);
        top_b   = lane_k(vert_reg, 0);
        top_c   = lane_k(vert_reg, 1);
        bot_b   = lane_k(vert_reg, 2);
        bot_c   = lane_k(vert_reg, 3);
    end

    // ------------------------------------------------------------------
    // Stage valids and elastic load enables
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    assign en5 = !v5_reg || result.ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign sphere.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= sphere.valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: centre times matrix entries (nine products)
    // Stage 2: sum the products plus translation -> view space
    // ------------------------------------------------------------------
    logic signed [PW-1:0]  prod_s1_reg [3][3];
    logic        [CW-2:0]  r_s1_reg, r_s2_reg, r_s3_reg;
    logic signed [VW-1:0]  v_s2_reg [3];
    logic signed [VW-1:0]  v_s2_next [3];
    logic signed [CW-1:0]  c_in [3];

    assign c_in[0] = sphere.center_x;
    assign c_in[1] = sphere.center_y;
    assign c_in[2] = sphere.center_z;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            v_s2_next[j] = VW'(prod_s1_reg[0][j]) + VW'(prod_s1_reg[1][j])
                         + VW'(prod_s1_reg[2][j]) + (VW'(off[j]) <<< KF);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_s1_reg[i][j] <= PW'(m[i][j]) * PW'(c_in[i]);
                end
            end
            r_s1_reg <= sphere.radius;
        end
        if (en2)
        begin
            v_s2_reg <= v_s2_next;
            r_s2_reg <= r_s1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: near/far clip test; plane partial products start here
    // Stage 4: radius scaled to plane units; plane sums registered
    // ------------------------------------------------------------------
    logic signed [NW-1:0] r1_wide, vz_wide, near_wide, far_wide;
    logic                 nf_cull_s3_reg, nf_cull_s4_reg;
    logic [R2W-1:0]       r2_s4_reg;

    always_comb
    begin
        r1_wide   = NW'($signed({1'b0, r_s2_reg})) <<< KF;
        vz_wide   = NW'(v_s2_reg[2]);
        near_wide = NW'(near_c) <<< KF;
        far_wide  = NW'(far_c) <<< KF;
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            nf_cull_s3_reg <= (near_wide > vz_wide + r1_wide)
                           || (vz_wide - r1_wide > far_wide);
            r_s3_reg       <= r_s2_reg;
        end
        if (en4)
        begin
            nf_cull_s4_reg <= nf_cull_s3_reg;
            r2_s4_reg      <= R2W'(r_s3_reg) << (2 * KF);
        end
    end

    pipe_en_t plane_en;
    logic [3:0] outside;

    assign plane_en.prod = en3;
    assign plane_en.sum  = en4;

    sfc_plane_test #(.VW(VW), .KW(KW), .R2W(R2W)) u_left (
        .clk(clk), .en(plane_en), .p(v_s2_reg[0]), .vz(v_s2_reg[2]),
        .k0(left_a), .k1(left_c), .r2(r2_s4_reg), .outside(outside[0])
    );

    sfc_plane_test #(.VW(VW), .KW(KW), .R2W(R2W)) u_right (
        .clk(clk), .en(plane_en), .p(v_s2_reg[0]), .vz(v_s2_reg[2]),
        .k0(right_a), .k1(right_c), .r2(r2_s4_reg), .outside(outside[1])
    );

    sfc_plane_test #(.VW(VW), .KW(KW), .R2W(R2W)) u_top (
        .clk(clk), .en(plane_en), .p(v_s2_reg[1]), .vz(v_s2_reg[2]),
        .k0(top_b), .k1(top_c), .r2(r2_s4_reg), .outside(outside[2])
    );

    sfc_plane_test #(.VW(VW), .KW(KW), .R2W(R2W)) u_bottom (
        .clk(clk), .en(plane_en), .p(v_s2_reg[1]), .vz(v_s2_reg[2]),
        .k0(bot_b), .k1(bot_c), .r2(r2_s4_reg), .outside(outside[3])
    );

    // ------------------------------------------------------------------
    // Stage 5: plane compares folded into the output register
    // ------------------------------------------------------------------
    logic visible_reg;

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            visible_reg <= !(nf_cull_s4_reg || (|outside));
        end
    end

    assign result.valid   = v5_reg;
    assign result.visible = visible_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_fills_s1 : assert property (@(posedge clk) disable iff (!rst_n)
        (sphere.valid && sphere.ready) |=> v1_reg)
        else $error("accepted sphere did not reach stage 1");

    a_stall_holds_s3 : assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !en4) |=> v3_reg)
        else $error("stage 3 item lost during stall");

    a_ready_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        !sphere.ready |-> (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg))
        else $error("input stalled with a pipeline bubble");

    a_clip_cull_reported : assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && en5 && nf_cull_s4_reg) |=> (v5_reg && !visible_reg))
        else $error("near/far cull not reported");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sphere/frustum cull block. A local fixed-point
// model of the view transform and the six frustum tests predicts the visible
// flag of every accepted sphere. Directed cases cover the clip and plane
// boundaries and extreme operands. Randomized phases follow, with both
// channels idling and stalling at random.
// ----------------------------------------------------------------------------
module testbench;
    import sfc_pkg::*;

    localparam int COORD_W          = COORD_WIDTH_DEF;
    localparam int COEFF_W          = COEFF_WIDTH_DEF;
    localparam int COEFF_FRAC       = COEFF_W - 2;
    localparam int NUM_CFG_REGS     = int'(REG_NEAR_FAR_CLIP) + 1;
    localparam int ONE              = 1 << (COORD_W / 2);   // 1.0 as a coordinate
    localparam int UNIT_COEFF       = 1 << COEFF_FRAC;      // 1.0 as a coefficient
    localparam int PLANE_K          = 3 * UNIT_COEFF / 4;   // 0.75, exact in Q2.14
    localparam int FAR_DIST         = 100 * ONE;
    localparam int SCENE_SPAN       = 1500;                 // scene half-size, world units
    localparam int MAX_SCENE_RADIUS = 60;
    localparam int BASIS_JITTER     = 3000;
    localparam int MAX_GAP          = 10;
    localparam int HOLD_OFF_CYCLES  = 200;
    localparam int PIPE_LATENCY     = 5;
    localparam int DRAIN_LIMIT      = 2000;
    localparam int MAX_REPORTED     = 10;
    localparam int RANDOM_PHASES    = 8;
    localparam int PHASE_ITEMS      = 45;

    // Wide enough that no product or sum of the cull math can wrap.
    typedef logic signed [127:0] exact_t;

    typedef struct {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic        [COORD_W-2:0] radius;
    } sphere_t;

    typedef struct {
        int unsigned seq;
        bit          visible;
    } verdict_t;

    logic clk;
    logic rst_n;

    sfc_sphere_if #(.COORD_WIDTH(COORD_W)) sphere_ch ();
    sfc_result_if                          result_ch ();
    sfc_cfg_if                             cfg_ch ();

    sphere_frustum_cull_top #(
        .COORD_WIDTH (COORD_W),
        .COEFF_WIDTH (COEFF_W)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sphere (sphere_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Shadow copy of the config registers, as the block should hold them.
    // One entry per index code; unmapped entries are never written.
    logic [63:0] view_regs [2**CFG_INDEX_WIDTH];

    // Expected visible flags, oldest first.
    verdict_t    verdict_q [$];

    int unsigned sent_count     = 0;
    int unsigned mismatch_count = 0;

    // Idle controls shared by the test tasks and the result sink.
    int tx_gap_max     = MAX_GAP;
    int rx_stall_max   = MAX_GAP;
    int rx_hold_cycles = 0;

    // ------------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: fails the run if the main sequence never finishes.
    initial
    begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Cull predictor
    // ------------------------------------------------------------------------
    function automatic exact_t coeff_lane(logic [63:0] word, int idx);
        logic signed [COEFF_W-1:0] c;
        exact_t                    v;
        c = word[idx*COEFF_W +: COEFF_W];
        v = exact_t'(c);
        return v;
    endfunction

    function automatic exact_t coord_lane(logic [63:0] word, int idx);
        logic signed [COORD_W-1:0] c;
        exact_t                    v;
        c = word[idx*COORD_W +: COORD_W];
        v = exact_t'(c);
        return v;
    endfunction

    // One view-space axis, scaled by 2^(coord frac + coeff frac).
    function automatic exact_t view_axis(logic [63:0] basis, exact_t offset,
                                         exact_t x, exact_t y, exact_t z);
        return coeff_lane(basis, 0) * x + coeff_lane(basis, 1) * y
             + coeff_lane(basis, 2) * z + (offset <<< COEFF_FRAC);
    endfunction

    // Signed distance past one side plane against the radius (strictly greater culls).
    function automatic bit beyond_plane(exact_t p, exact_t vz, logic [63:0] planes,
                                        int first, exact_t r_scaled);
        return p * coeff_lane(planes, first) + vz * coeff_lane(planes, first + 1)
             > r_scaled;
    endfunction

    function automatic bit predict_visibility(sphere_t s);
        exact_t x, y, z, r, r1, r2, vx, vy, vz, near_d, far_d;
        x  = exact_t'(s.center_x);
        y  = exact_t'(s.center_y);
        z  = exact_t'(s.center_z);
        r  = exact_t'(s.radius);
        r1 = r <<< COEFF_FRAC;
        r2 = r <<< (2 * COEFF_FRAC);

        vz     = view_axis(view_regs[REG_VIEW_BASIS_Z],
                           coord_lane(view_regs[REG_VIEW_OFFSET_Z], 0), x, y, z);
        near_d = coord_lane(view_regs[REG_NEAR_FAR_CLIP], 0) <<< COEFF_FRAC;
        far_d  = coord_lane(view_regs[REG_NEAR_FAR_CLIP], 1) <<< COEFF_FRAC;
        if (near_d > vz + r1 || vz - r1 > far_d)
            return 1'b0;

        vx = view_axis(view_regs[REG_VIEW_BASIS_X],
                       coord_lane(view_regs[REG_VIEW_OFFSET_XY], 0), x, y, z);
        vy = view_axis(view_regs[REG_VIEW_BASIS_Y],
                       coord_lane(view_regs[REG_VIEW_OFFSET_XY], 1), x, y, z);
        return !(beyond_plane(vx, vz, view_regs[REG_SIDE_PLANES], 0, r2)
              || beyond_plane(vx, vz, view_regs[REG_SIDE_PLANES], 2, r2)
              || beyond_plane(vy, vz, view_regs[REG_VERTICAL_PLANES], 0, r2)
              || beyond_plane(vy, vz, view_regs[REG_VERTICAL_PLANES], 2, r2));
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [63:0] pack_coeffs(int lanes [4]);
        logic [63:0] v;
        v = '0;
        foreach (lanes[i])
            v[i*COEFF_W +: COEFF_W] = COEFF_W'(lanes[i]);
        return v;
    endfunction

    function automatic int jitter(int base);
        return base + int'($urandom_range(0, 2 * BASIS_JITTER)) - BASIS_JITTER;
    endfunction

    function automatic int plane_mag();
        return int'($urandom_range(4000, UNIT_COEFF - 1));
    endfunction

    function automatic int scene_coord();
        return int'($urandom_range(0, 2 * SCENE_SPAN * ONE)) - SCENE_SPAN * ONE;
    endfunction

    // Register value with a bias toward saturated lanes.
    function automatic logic [63:0] wild_word();
        case ($urandom_range(0, 5))
            0:       return {4{16'h8000}};
            1:       return {4{16'h7FFF}};
            2:       return {2{32'h8000_0000}};
            3:       return {2{32'h7FFF_FFFF}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic sphere_t sphere_at(int x, int y, int z, int r);
        sphere_t s;
        s.center_x = x;
        s.center_y = y;
        s.center_z = z;
        s.radius   = (COORD_W-1)'(r);
        return s;
    endfunction

    // Mostly spheres spread around the scene; a quarter are raw bit noise.
    function automatic sphere_t rand_sphere();
        sphere_t s;
        if ($urandom_range(0, 3) == 0)
            s = sphere_at($urandom, $urandom, $urandom, $urandom);
        else
            s = sphere_at(scene_coord(), scene_coord(), scene_coord(),
                          $urandom_range(0, MAX_SCENE_RADIUS * ONE));
        return s;
    endfunction

    function automatic void log_mismatch(string what);
        if (mismatch_count < MAX_REPORTED)
            $display("%0t: %s", $time, what);
        mismatch_count++;
    endfunction

    // ------------------------------------------------------------------------
    // Channel tasks
    // ------------------------------------------------------------------------
    // Writes take effect at the accepting edge; out-of-range indexes are dropped.
    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [63:0] value);
        int w;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        if (idx < NUM_CFG_REGS)
        begin
            case (cfg_reg_t'(idx))
                REG_VIEW_BASIS_X, REG_VIEW_BASIS_Y, REG_VIEW_BASIS_Z: w = BASIS_WIDTH;
                REG_VIEW_OFFSET_XY:                     w = OFFSET_XY_WIDTH;
                REG_VIEW_OFFSET_Z:                      w = OFFSET_Z_WIDTH;
                REG_SIDE_PLANES, REG_VERTICAL_PLANES:   w = PLANES_WIDTH;
                default:                                w = CLIP_WIDTH;
            endcase
            view_regs[idx] = (w >= 64) ? value : value & ((64'd1 << w) - 64'd1);
        end
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Leaves valid high after the transaction so back-to-back items need no
    // extra edge; a gap or release_sphere drops it.
    task automatic send_sphere(sphere_t s);
        int       gap;
        verdict_t v;
        gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
        if (gap > 0)
        begin
            sphere_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sphere_ch.valid    <= 1'b1;
        sphere_ch.center_x <= s.center_x;
        sphere_ch.center_y <= s.center_y;
        sphere_ch.center_z <= s.center_z;
        sphere_ch.radius   <= s.radius;
        do @(posedge clk); while (!sphere_ch.ready);
        v.seq     = sent_count;
        v.visible = predict_visibility(s);
        verdict_q.push_back(v);
        sent_count++;
    endtask

    task automatic release_sphere();
        sphere_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_results_drained();
        int waited;
        waited = 0;
        while (verdict_q.size() > 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    // Plausible camera: near-identity rotation, inward-facing planes, near < far.
    // Otherwise every register gets raw or saturated content.
    task automatic load_random_view(bit plausible);
        if (plausible)
        begin
            write_reg(REG_VIEW_BASIS_X,
                      pack_coeffs('{jitter(UNIT_COEFF), jitter(0), jitter(0), $urandom}));
            write_reg(REG_VIEW_BASIS_Y,
                      pack_coeffs('{jitter(0), jitter(UNIT_COEFF), jitter(0), $urandom}));
            write_reg(REG_VIEW_BASIS_Z,
                      pack_coeffs('{jitter(0), jitter(0), jitter(UNIT_COEFF), $urandom}));
            write_reg(REG_VIEW_OFFSET_XY,
                      {int'($urandom_range(0, 100 * ONE)) - 50 * ONE,
                       int'($urandom_range(0, 100 * ONE)) - 50 * ONE});
            write_reg(REG_VIEW_OFFSET_Z,
                      {$urandom, int'($urandom_range(0, 100 * ONE)) - 50 * ONE});
            write_reg(REG_SIDE_PLANES,
                      pack_coeffs('{-plane_mag(), -plane_mag(), plane_mag(), -plane_mag()}));
            write_reg(REG_VERTICAL_PLANES,
                      pack_coeffs('{plane_mag(), -plane_mag(), -plane_mag(), -plane_mag()}));
            write_reg(REG_NEAR_FAR_CLIP,
                      {int'($urandom_range(50 * ONE, 2000 * ONE)),
                       int'($urandom_range(0, 5 * ONE))});
        end
        else
        begin
            for (int i = 0; i < NUM_CFG_REGS; i++)
                write_reg(CFG_INDEX_WIDTH'(i), wild_word());
        end
        // Stray write to an unmapped index; must not disturb anything.
        if ($urandom_range(0, 1) == 1)
            write_reg(CFG_INDEX_WIDTH'(NUM_CFG_REGS
                          + $urandom_range(0, 2**CFG_INDEX_WIDTH - 1 - NUM_CFG_REGS)),
                      {$urandom, $urandom});
    endtask

    // ------------------------------------------------------------------------
    // Result sink: random stalls per transaction, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int stall;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
            end
            stall = (rx_stall_max > 0) ? $urandom_range(0, rx_stall_max) : 0;
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: each result transaction against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        verdict_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (verdict_q.size() == 0)
                log_mismatch($sformatf("result with nothing pending, visible=%0b",
                                       result_ch.visible));
            else
            begin
                want = verdict_q.pop_front();
                if (result_ch.visible !== want.visible)
                    log_mismatch($sformatf("sphere %0d: visible expected %0b, got %0b",
                                           want.seq, want.visible, result_ch.visible));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Zeroed config: every test compares zeros, so all spheres come out visible.
    task automatic test_reset_defaults();
        send_sphere(sphere_at(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_sphere(sphere_at(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0));
        send_sphere(sphere_at(0, 0, 0, 0));
        send_sphere(rand_sphere());
        release_sphere();
    endtask

    // Axis-aligned camera with 0.75 planes, near 1, far 100. Spheres sit just
    // inside, exactly on, and just past each boundary; touching is not culled.
    task automatic test_cull_boundaries();
        wait_results_drained();
        // Junk above each register's width must be dropped.
        write_reg(REG_VIEW_BASIS_X, pack_coeffs('{UNIT_COEFF, 0, 0, -1}));
        write_reg(REG_VIEW_BASIS_Y, pack_coeffs('{0, UNIT_COEFF, 0, -1}));
        write_reg(REG_VIEW_BASIS_Z, pack_coeffs('{0, 0, UNIT_COEFF, -1}));
        write_reg(REG_VIEW_OFFSET_XY, '0);
        write_reg(REG_VIEW_OFFSET_Z, {32'hFFFF_FFFF, 32'd0});
        write_reg(REG_SIDE_PLANES, pack_coeffs('{-PLANE_K, -PLANE_K, PLANE_K, -PLANE_K}));
        write_reg(REG_VERTICAL_PLANES, pack_coeffs('{PLANE_K, -PLANE_K, -PLANE_K, -PLANE_K}));
        write_reg(REG_NEAR_FAR_CLIP, {FAR_DIST, ONE});
        // Unmapped indexes at both ends of the free range.
        write_reg(CFG_INDEX_WIDTH'(NUM_CFG_REGS), '1);
        write_reg(CFG_INDEX_WIDTH'(2**CFG_INDEX_WIDTH - 1), '1);

        send_sphere(sphere_at(0, 0, 10 * ONE, ONE));                  // plainly inside
        send_sphere(sphere_at(0, 0, ONE / 2, ONE / 4));               // short of near
        send_sphere(sphere_at(0, 0, ONE / 2, ONE / 2));               // touches near
        send_sphere(sphere_at(0, 0, 200 * ONE, ONE));                 // past far
        send_sphere(sphere_at(0, 0, 101 * ONE, ONE));                 // touches far
        send_sphere(sphere_at(-50 * ONE, 0, 10 * ONE, ONE));          // left
        send_sphere(sphere_at(50 * ONE, 0, 10 * ONE, ONE));           // right
        send_sphere(sphere_at(0, 50 * ONE, 10 * ONE, ONE));           // top
        send_sphere(sphere_at(0, -50 * ONE, 10 * ONE, ONE));          // bottom
        send_sphere(sphere_at(-10 * ONE, 0, 10 * ONE, 0));            // centre on left plane
        send_sphere(sphere_at(-11 * ONE, 0, 10 * ONE, 3 * ONE / 4));  // grazes left plane
        send_sphere(sphere_at(-11 * ONE, 0, 10 * ONE, 3 * ONE / 4 - 1)); // one lsb short
        release_sphere();
    endtask

    // Saturated lanes everywhere, against saturated centres and radii.
    task automatic test_extreme_values();
        logic [63:0] fill [2];
        fill = '{{4{16'h7FFF}}, {4{16'h8000}}};
        foreach (fill[k])
        begin
            wait_results_drained();
            for (int i = 0; i < NUM_CFG_REGS; i++)
                write_reg(CFG_INDEX_WIDTH'(i), fill[k]);
            send_sphere(sphere_at(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
            send_sphere(sphere_at(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0));
            send_sphere(sphere_at(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
            send_sphere(sphere_at(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1));
            release_sphere();
        end
    endtask

    // Random cameras, mostly plausible; idling alternates between none, one
    // side only, and both sides.
    task automatic test_random_views();
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_results_drained();
            load_random_view(phase % 3 != 2);
            tx_gap_max   = (phase % 4 == 0 || phase % 4 == 1) ? 0 : MAX_GAP;
            rx_stall_max = (phase % 4 == 0 || phase % 4 == 2) ? 0 : MAX_GAP;
            repeat (PHASE_ITEMS) send_sphere(rand_sphere());
            release_sphere();
        end
        tx_gap_max   = MAX_GAP;
        rx_stall_max = MAX_GAP;
    endtask

    // Receiver holds off for a long stretch while spheres arrive back to back,
    // so all stages fill and sphere.ready has to drop.
    task automatic test_output_hold_off();
        wait_results_drained();
        load_random_view(1'b1);
        tx_gap_max     = 0;
        rx_hold_cycles = HOLD_OFF_CYCLES;
        repeat (40) send_sphere(rand_sphere());
        release_sphere();
        tx_gap_max = MAX_GAP;
    endtask

    // Sender stops mid-stream until the block has fully drained, then resumes.
    task automatic test_sender_pause();
        wait_results_drained();
        load_random_view(1'b1);
        repeat (20) send_sphere(rand_sphere());
        release_sphere();
        wait_results_drained();
        repeat (20) send_sphere(rand_sphere());
        release_sphere();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        sphere_ch.valid    <= 1'b0;
        sphere_ch.center_x <= '0;
        sphere_ch.center_y <= '0;
        sphere_ch.center_z <= '0;
        sphere_ch.radius   <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= '0;
        cfg_ch.data        <= '0;
        foreach (view_regs[i])
            view_regs[i] = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_cull_boundaries();
        test_extreme_values();
        test_random_views();
        test_output_hold_off();
        test_sender_pause();

        // Let any stray extra result show up before judging.
        wait_results_drained();
        repeat (2 * PIPE_LATENCY) @(posedge clk);
        if (verdict_q.size() > 0)
            log_mismatch($sformatf("%0d results never arrived", verdict_q.size()));

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/sfc_pkg.sv
hdl/sfc_if.sv
hdl/sfc_plane_test.sv
hdl/sphere_frustum_cull_top.sv
test/testbench.sv
